>>> rtl/core/gaussian_elimination_solver_core_defines.svh
// ----------------------------------------------------------------------------
// Gaussian elimination solver: shared assertion macros
// Clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_ELIMINATION_SOLVER_CORE_DEFINES_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define GES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// Constants, command/status types and address helper for the solver core.
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int MAX_UNK     = 16;
  localparam int STORE_DEPTH = MAX_UNK * (MAX_UNK + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(MAX_UNK + 2);
  localparam int IDX_W       = $clog2(MAX_UNK);

  // source of store write data
  typedef enum logic [1:0] {
    WR_COEF = 2'd0,
    WR_RDQ  = 2'd1,
    WR_TMP  = 2'd2,
    WR_DIFF = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_t           wr_sel;
    logic              tmp_ld;
    logic              mag_ld;
    logic              piv_ld;
    logic              div_start;
    logic              div_bs;     // back substitution operands
    logic              prod_ld;
    logic              mq_ld;
    logic              fac_ld;
    logic              x_wr;
    logic [IDX_W-1:0]  x_idx;
    logic [IDX_W-1:0]  out_idx;
    logic              out_zero;
  } ges_cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic mag_gt;
    logic div_done;
  } ges_sts_t;

  // flat store address of (row, col) with row stride w
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CNT_W-1:0] row,
                                                 input logic [CNT_W-1:0] col,
                                                 input logic [CNT_W-1:0] w);
    logic [2*CNT_W-1:0] p;
    p = {{CNT_W{1'b0}}, row} * {{CNT_W{1'b0}}, w};
    return p[ADDR_W-1:0] + ADDR_W'(col);
  endfunction

endpackage

>>> rtl/core/ges_div.sv
// ----------------------------------------------------------------------------
// ges_div
// Radix-2 restoring divider for Q16.16: sat((num << 16) / den), toward zero; 0 when den is 0.
// ----------------------------------------------------------------------------
module ges_div
  import ges_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [DATA_W-1:0] quo
);

  localparam int QW = DATA_W + 16;

  logic              busy;
  logic              fin;
  logic [5:0]        cnt;
  logic [DATA_W-1:0] rem;
  logic [QW-1:0]     qr;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic              zden;

  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] nmag;

  assign nmag  = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign trial = {rem, qr[QW-1]};
  assign ge    = trial >= {1'b0, dmag};
  assign diff  = trial - {1'b0, dmag};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      zden <= (den == '0);
      dmag <= den[DATA_W-1] ? (~den + 1'b1) : den;
      qr   <= {nmag, 16'd0};
      rem  <= '0;
    end else if (busy) begin
      qr  <= {qr[QW-2:0], ge};
      rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end
  end

  // sign and saturate
  always_ff @(posedge clk) begin
    if (fin) begin
      if (zden) begin
        quo <= '0;
      end else if (neg) begin
        if (qr > QW'(33'h080000000)) quo <= 32'h8000_0000;
        else                          quo <= ~qr[DATA_W-1:0] + 1'b1;
      end else begin
        if (qr > QW'(32'h7FFF_FFFF)) quo <= 32'h7FFF_FFFF;
        else                          quo <= qr[DATA_W-1:0];
      end
    end
  end

endmodule

>>> rtl/core/ges_datapath.sv
// ----------------------------------------------------------------------------
// ges_datapath
// Matrix store, multiplier, divider, saturation and the solution registers.
// ----------------------------------------------------------------------------
module ges_datapath
  import ges_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ges_cmd_t          cmd,
  input  logic [DATA_W-1:0] coef,
  output ges_sts_t          sts,
  output logic [DATA_W-1:0] out_value
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdq;
  logic [DATA_W-1:0] tmp;
  logic [DATA_W-1:0] piv;
  logic [DATA_W-1:0] fac;
  logic [DATA_W-1:0] bestmag;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0] mq;
  logic [DATA_W-1:0] xs [MAX_UNK];

  logic [DATA_W-1:0] rdmag;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] diff;
  logic [DATA_W:0]   d33;
  logic [47:0]       q48;
  logic [DATA_W-1:0] qsat;
  logic              div_done;
  logic [DATA_W-1:0] quo;

  // store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdq <= mem[cmd.rd_addr];
  end

  // saturating difference
  assign d33  = {rdq[DATA_W-1], rdq} - {mq[DATA_W-1], mq};
  assign diff = (d33[DATA_W] != d33[DATA_W-1])
                ? (d33[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF) : d33[DATA_W-1:0];

  always_comb begin
    case (cmd.wr_sel)
      WR_COEF: wdata = coef;
      WR_RDQ:  wdata = rdq;
      WR_TMP:  wdata = tmp;
      WR_DIFF: wdata = diff;
      default: wdata = coef;
    endcase
  end

  // product scaled by 2^-16 toward zero, then saturated
  assign q48 = prod[2*DATA_W-1:16] + 48'(prod[2*DATA_W-1] && (prod[15:0] != 16'd0));
  always_comb begin
    if (!q48[47] && (q48[46:31] != 16'd0))      qsat = 32'h7FFF_FFFF;
    else if (q48[47] && (q48[46:31] != 16'hFFFF)) qsat = 32'h8000_0000;
    else                                          qsat = q48[DATA_W-1:0];
  end

  assign rdmag = rdq[DATA_W-1] ? (~rdq + 1'b1) : rdq;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.tmp_ld)  tmp     <= rdq;
    if (cmd.piv_ld)  piv     <= rdq;
    if (cmd.mag_ld)  bestmag <= rdmag;
    if (cmd.prod_ld) prod    <= $signed(fac) * $signed(rdq);
    if (cmd.mq_ld)   mq      <= qsat;
    if (cmd.fac_ld)  fac     <= quo;
    if (cmd.x_wr)    xs[cmd.x_idx] <= quo;
  end

  ges_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_bs ? tmp : rdq),
    .den   (cmd.div_bs ? rdq : piv),
    .done  (div_done),
    .quo   (quo)
  );

  assign sts.rd_zero  = (rdq == '0);
  assign sts.mag_gt   = rdmag > bestmag;
  assign sts.div_done = div_done;

  assign out_value = cmd.out_zero ? '0 : xs[cmd.out_idx];

endmodule

>>> rtl/core/ges_ctrl.sv
// ----------------------------------------------------------------------------
// ges_ctrl
// Sequencer: loading, pivot search, row swap, elimination, back substitution.
// ----------------------------------------------------------------------------
`include "gaussian_elimination_solver_core_defines.svh"

module ges_ctrl
  import ges_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             m_tlast,
  output logic [IDX_W-1:0] out_index,
  output logic             out_singular,
  output ges_cmd_t         cmd,
  input  ges_sts_t         sts
);

  typedef enum logic [26:0] {
    S_LOAD     = 27'd1 << 0,
    S_PS_INIT  = 27'd1 << 1,
    S_PS_FIRST = 27'd1 << 2,
    S_PS_CMP   = 27'd1 << 3,
    S_SW_CHK   = 27'd1 << 4,
    S_SW_RDA   = 27'd1 << 5,
    S_SW_RDB   = 27'd1 << 6,
    S_SW_WRA   = 27'd1 << 7,
    S_SW_WRB   = 27'd1 << 8,
    S_PV_RD    = 27'd1 << 9,
    S_PV_CHK   = 27'd1 << 10,
    S_EL_K     = 27'd1 << 11,
    S_EL_DIV   = 27'd1 << 12,
    S_EL_DWAIT = 27'd1 << 13,
    S_EL_RDU   = 27'd1 << 14,
    S_EL_MUL   = 27'd1 << 15,
    S_EL_SAT   = 27'd1 << 16,
    S_EL_SUB   = 27'd1 << 17,
    S_BS_RDB   = 27'd1 << 18,
    S_BS_RDP   = 27'd1 << 19,
    S_BS_DIV   = 27'd1 << 20,
    S_BS_DWAIT = 27'd1 << 21,
    S_BS_J     = 27'd1 << 22,
    S_BS_MUL   = 27'd1 << 23,
    S_BS_SAT   = 27'd1 << 24,
    S_BS_SUB   = 27'd1 << 25,
    S_OUT      = 27'd1 << 26
  } state_t;

  state_t            state, state_next;
  logic [4:0]        size, size_next;
  logic [ADDR_W-1:0] load_count, load_count_next;
  logic [CNT_W-1:0]  i, i_next, j, j_next, k, k_next, best, best_next, oidx, oidx_next;
  logic              sing, sing_next;

  logic [CNT_W-1:0]   n, w;
  logic [2*CNT_W-1:0] total_w;
  logic [ADDR_W-1:0]  total;

  // active size clamped to 1..MAX_UNK
  always_comb begin
    if (size == 5'd0)                n = CNT_W'(1);
    else if (size > 5'(MAX_UNK))     n = CNT_W'(MAX_UNK);
    else                             n = CNT_W'(size);
  end
  assign w       = n + CNT_W'(1);
  assign total_w = {{CNT_W{1'b0}}, n} * {{CNT_W{1'b0}}, w};
  assign total   = total_w[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      size       <= 5'd1;
      load_count <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      best       <= '0;
      oidx       <= '0;
      sing       <= 1'b0;
    end else begin
      state      <= state_next;
      size       <= size_next;
      load_count <= load_count_next;
      i          <= i_next;
      j          <= j_next;
      k          <= k_next;
      best       <= best_next;
      oidx       <= oidx_next;
      sing       <= sing_next;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    size_next       = size;
    load_count_next = load_count;
    i_next          = i;
    j_next          = j;
    k_next          = k;
    best_next       = best;
    oidx_next       = oidx;
    sing_next       = sing;
    cmd             = '0;
    cmd.out_idx     = oidx[IDX_W-1:0];
    cmd.out_zero    = sing;
    s_tready        = 1'b0;
    m_tvalid        = 1'b0;

    case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (load_count < total) begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr     = load_count;
            cmd.wr_sel      = WR_COEF;
            load_count_next = load_count + 1'b1;
          end
          if (s_tlast) begin
            load_count_next = '0;
            i_next          = '0;
            sing_next       = 1'b0;
            state_next      = S_PS_INIT;
          end
        end
      end
      // pivot search over column i
      S_PS_INIT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, i, w);
        best_next   = i;
        j_next      = i + CNT_W'(1);
        state_next  = S_PS_FIRST;
      end
      S_PS_FIRST: begin
        cmd.mag_ld = 1'b1;
        if (j < n) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = mem_addr(j, i, w);
          state_next  = S_PS_CMP;
        end else begin
          state_next = S_SW_CHK;
        end
      end
      S_PS_CMP: begin
        if (sts.mag_gt) begin
          cmd.mag_ld = 1'b1;
          best_next  = j;
        end
        if (j + CNT_W'(1) < n) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = mem_addr(j + CNT_W'(1), i, w);
          j_next      = j + CNT_W'(1);
        end else begin
          state_next = S_SW_CHK;
        end
      end
      // whole-row swap
      S_SW_CHK: begin
        if (best != i) begin
          j_next     = '0;
          state_next = S_SW_RDA;
        end else begin
          state_next = S_PV_RD;
        end
      end
      S_SW_RDA: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(best, j, w);
        state_next  = S_SW_RDB;
      end
      S_SW_RDB: begin
        cmd.tmp_ld  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, j, w);
        state_next  = S_SW_WRA;
      end
      S_SW_WRA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = mem_addr(best, j, w);
        cmd.wr_sel  = WR_RDQ;
        state_next  = S_SW_WRB;
      end
      S_SW_WRB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = mem_addr(i, j, w);
        cmd.wr_sel  = WR_TMP;
        j_next      = j + CNT_W'(1);
        state_next  = (j + CNT_W'(1) == w) ? S_PV_RD : S_SW_RDA;
      end
      // pivot check
      S_PV_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, i, w);
        state_next  = S_PV_CHK;
      end
      S_PV_CHK: begin
        cmd.piv_ld = 1'b1;
        if (sts.rd_zero) begin
          sing_next  = 1'b1;
          oidx_next  = '0;
          state_next = S_OUT;
        end else begin
          k_next     = i + CNT_W'(1);
          state_next = S_EL_K;
        end
      end
      // elimination of rows below the pivot
      S_EL_K: begin
        if (k < n) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = mem_addr(k, i, w);
          state_next  = S_EL_DIV;
        end else if (i + CNT_W'(1) < n) begin
          i_next     = i + CNT_W'(1);
          state_next = S_PS_INIT;
        end else begin
          i_next     = n - CNT_W'(1);
          state_next = S_BS_RDB;
        end
      end
      S_EL_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_EL_DWAIT;
      end
      S_EL_DWAIT: begin
        if (sts.div_done) begin
          cmd.fac_ld = 1'b1;
          j_next     = i + CNT_W'(1);
          state_next = S_EL_RDU;
        end
      end
      S_EL_RDU: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, j, w);
        state_next  = S_EL_MUL;
      end
      S_EL_MUL: begin
        cmd.prod_ld = 1'b1;
        state_next  = S_EL_SAT;
      end
      S_EL_SAT: begin
        cmd.mq_ld   = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(k, j, w);
        state_next  = S_EL_SUB;
      end
      S_EL_SUB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = mem_addr(k, j, w);
        cmd.wr_sel  = WR_DIFF;
        j_next      = j + CNT_W'(1);
        if (j + CNT_W'(1) < w) begin
          state_next = S_EL_RDU;
        end else begin
          k_next     = k + CNT_W'(1);
          state_next = S_EL_K;
        end
      end
      // back substitution, last row first
      S_BS_RDB: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, n, w);
        state_next  = S_BS_RDP;
      end
      S_BS_RDP: begin
        cmd.tmp_ld  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(i, i, w);
        state_next  = S_BS_DIV;
      end
      S_BS_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_bs    = 1'b1;
        state_next    = S_BS_DWAIT;
      end
      S_BS_DWAIT: begin
        cmd.div_bs = 1'b1;
        if (sts.div_done) begin
          cmd.fac_ld = 1'b1;
          cmd.x_wr   = 1'b1;
          cmd.x_idx  = i[IDX_W-1:0];
          j_next     = '0;
          state_next = S_BS_J;
        end
      end
      S_BS_J: begin
        if (j < i) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = mem_addr(j, i, w);
          state_next  = S_BS_MUL;
        end else if (i == '0) begin
          oidx_next  = '0;
          state_next = S_OUT;
        end else begin
          i_next     = i - CNT_W'(1);
          state_next = S_BS_RDB;
        end
      end
      S_BS_MUL: begin
        cmd.prod_ld = 1'b1;
        state_next  = S_BS_SAT;
      end
      S_BS_SAT: begin
        cmd.mq_ld   = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = mem_addr(j, n, w);
        state_next  = S_BS_SUB;
      end
      S_BS_SUB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = mem_addr(j, n, w);
        cmd.wr_sel  = WR_DIFF;
        j_next      = j + CNT_W'(1);
        state_next  = S_BS_J;
      end
      // results in index order
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (oidx + CNT_W'(1) == n) state_next = S_LOAD;
          else                       oidx_next  = oidx + CNT_W'(1);
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    // register write takes the new size and clears the load count
    if (cfg_we) begin
      size_next       = cfg_wdata;
      load_count_next = '0;
    end
  end

  assign out_index    = oidx[IDX_W-1:0];
  assign out_singular = sing;
  assign m_tlast      = (oidx + CNT_W'(1) == n);

  `GES_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input and output both open")
  `GES_ASSERT_IMP(a_load_bound, 1'b1, load_count <= total, "load count beyond matrix size")
  `GES_ASSERT_NXT(a_solve_start, s_tvalid && s_tready && s_tlast && !cfg_we, !s_tready,
                  "input still open after last coefficient")
  `GES_ASSERT_IMP(a_out_index, m_tvalid, oidx < n, "result index beyond system size")

endmodule

>>> rtl/core/gaussian_elimination_solver_core.sv
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_core
// Q16.16 linear system solver, partial pivoting and back substitution.
//
//   channel  dir  payload
//   cfg      in   cfg_wdata = system_size (write on cfg_we)
//   s_*      in   tdata = coef_value, tlast = last_coef
//   m_*      out  tdata = solution_value, solution_index; tlast, tuser = singular
//
// Loading takes one coefficient per cycle. Solving then runs on one store
// port, one multiplier and a bit-serial divider; results then leave one
// per cycle while m_tready is high. Reset is synchronous; the store needs
// no clearing. The output holds while m_tready is low; input is closed
// from the last coefficient until the final result is taken.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_core
  import ges_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,     // system_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // [31:0] coef_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // [31:0] solution_value, [35:32] solution_index
  output logic        m_tlast,
  output logic        m_tuser        // [0] singular
);

  ges_cmd_t          cmd;
  ges_sts_t          sts;
  logic [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]  out_index;

  ges_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tlast      (m_tlast),
    .out_index    (out_index),
    .out_singular (m_tuser),
    .cmd          (cmd),
    .sts          (sts)
  );

  ges_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .coef      (s_tdata),
    .sts       (sts),
    .out_value (out_value)
  );

  // result packing
  assign m_tdata = {4'd0, out_index, out_value};

endmodule

>>> sim/tb_gaussian_elimination_solver_core.sv
// ----------------------------------------------------------------------------
// Testbench for gaussian_elimination_solver_core
// Loads augmented matrices over the input stream, predicts each solution with
// a Q16.16 elimination model (partial pivoting, saturation, singular flag) and
// checks every output transaction against the oldest expected solution.
// ----------------------------------------------------------------------------
module tb_gaussian_elimination_solver_core
  import ges_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  idx;
    logic        last;
    logic        sing;
  } soln_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // model state
  logic signed [31:0] mdl_store [STORE_DEPTH];
  int unsigned        mdl_count;
  logic [4:0]         mdl_size;

  soln_t soln_q[$];
  int    errors;
  bit    src_idle_en;
  bit    snk_idle_en;
  int    hold_cycles;

  gaussian_elimination_solver_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Q16.16 helpers, saturating
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p / 64'sd65536);
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    if (b == 0) return 0;
    p = 64'(a) * 64'sd65536;
    return sat32(p / 64'(b));
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [32:0] q_mag(input logic signed [31:0] v);
    return v < 0 ? -33'(v) : 33'(v);
  endfunction

  function automatic int unsigned active_size();
    if (mdl_size == 0) return 1;
    if (mdl_size > MAX_UNK) return MAX_UNK;
    return mdl_size;
  endfunction

  // elimination and back substitution on the model store
  task automatic solve_system();
    int unsigned n, w, best;
    logic signed [31:0] piv, f, xi, t;
    logic signed [31:0] xs [MAX_UNK];
    bit sing;
    soln_t s;
    n = active_size();
    w = n + 1;
    sing = 0;
    for (int i = 0; i < n && !sing; i++) begin
      best = i;
      for (int j = i + 1; j < n; j++)
        if (q_mag(mdl_store[j*w+i]) > q_mag(mdl_store[best*w+i])) best = j;
      if (best != i) begin
        for (int j = 0; j < w; j++) begin
          t = mdl_store[best*w+j];
          mdl_store[best*w+j] = mdl_store[i*w+j];
          mdl_store[i*w+j] = t;
        end
      end
      piv = mdl_store[i*w+i];
      if (piv == 0) begin
        sing = 1;
      end else begin
        for (int k = i + 1; k < n; k++) begin
          f = q_div(mdl_store[k*w+i], piv);
          for (int j = i + 1; j < w; j++)
            mdl_store[k*w+j] = q_sub(mdl_store[k*w+j], q_mul(f, mdl_store[i*w+j]));
        end
      end
    end
    for (int i = 0; i < n; i++) xs[i] = 0;
    if (!sing) begin
      for (int i = n - 1; i >= 0; i--) begin
        xi = q_div(mdl_store[i*w+n], mdl_store[i*w+i]);
        xs[i] = xi;
        for (int j = 0; j < i; j++)
          mdl_store[j*w+n] = q_sub(mdl_store[j*w+n], q_mul(mdl_store[j*w+i], xi));
      end
    end
    for (int i = 0; i < n; i++) begin
      s.value = xs[i];
      s.idx   = 4'(i);
      s.last  = (i == n - 1);
      s.sing  = sing;
      soln_q.push_back(s);
    end
  endtask

  // one input transaction, with optional random idle burst before it
  task automatic send_coef(input logic [31:0] v, input bit last);
    int unsigned n;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = active_size();
    if (mdl_count < n * (n + 1)) begin
      mdl_store[mdl_count] = v;
      mdl_count++;
    end
    if (last) begin
      mdl_count = 0;
      solve_system();
    end
  endtask

  // sender goes quiet until every expected result has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (soln_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [4:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_size  = v;
    mdl_count = 0;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
      2:       return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      3:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
    endcase
  endfunction

  // full matrix for the current size, random content, or a zero first column or unit diagonal
  task automatic send_matrix(input int kind);
    int unsigned n, tot;
    logic [31:0] v;
    n = active_size();
    tot = n * (n + 1);
    for (int e = 0; e < tot; e++) begin
      v = rand_coef();
      if (kind == 1 && (e % (n + 1)) == 0) v = 0;       // zero column: singular
      if (kind == 2) v = ((e % (n + 1)) == e / (n + 1)) ? 32'h00010000 : v;
      send_coef(v, e == tot - 1);
    end
  endtask

  // extremes, identity, ties and sign bits
  task automatic test_directed();
    write_size(5'd1);
    send_coef(32'h00020000, 0);
    send_coef(32'h80000000, 1);
    send_coef(32'h00000001, 0);
    send_coef(32'h7fffffff, 1);
    send_coef(32'h00000000, 0);
    send_coef(32'hffffffff, 1);               // zero pivot
    write_size(5'd2);
    // equal magnitudes in column 0: lowest row wins
    send_coef(32'hfffe0000, 0); send_coef(32'h00010000, 0); send_coef(32'h00030000, 0);
    send_coef(32'h00020000, 0); send_coef(32'h00050000, 0); send_coef(32'h00070000, 1);
    // surplus elements then early last mark
    send_coef(32'h00010000, 0); send_coef(32'h00000000, 0); send_coef(32'h00010000, 0);
    send_coef(32'h00000000, 0); send_coef(32'h00010000, 0); send_coef(32'h00020000, 0);
    send_coef(32'h55555555, 0); send_coef(32'haaaaaaaa, 1);
    send_coef(32'h00030000, 1);                // early last mark
  endtask

  task automatic test_sizes();
    write_size(5'd0);                          // used as one
    send_matrix(0);
    write_size(5'd16);
    send_matrix(2);
    write_size(5'd31);                         // clipped to the maximum
    send_coef(rand_coef(), 0);
    send_coef(rand_coef(), 1);
    write_size(5'd3);
    send_matrix(1);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_size(5'd2);
    hold_cycles = 400;
    for (int r = 0; r < 4; r++) send_matrix(0);
    wait_drained();                            // sender pauses until all results are in
  endtask

  task automatic test_random(input int budget);
    int sent;
    logic [4:0] sz;
    sent = 0;
    while (sent < budget) begin
      sz = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(5, 6)) : 5'($urandom_range(1, 4));
      write_size(sz);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: send_matrix(1);
          1: begin
            // early last mark partway through
            repeat ($urandom_range(1, 3)) begin
              send_coef(rand_coef(), 0);
              sent++;
            end
            send_coef(rand_coef(), 1);
          end
          2: begin
            for (int e = 0; e < active_size() * (active_size() + 1) + 2; e++)
              send_coef(rand_coef(), 0);
            send_coef(rand_coef(), 1);
          end
          default: send_matrix(0);
        endcase
        sent += active_size() * (active_size() + 1);
      end
    end
  endtask

  // result sink with random stalls
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        while (!(s_tvalid && !s_tready)) @(posedge clk);
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // output checker
  always @(posedge clk) begin
    soln_t got, exp_s;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser};
      if (soln_q.size() == 0) begin
        $display("%0t: unexpected solution value=%h index=%0d", $realtime, got.value,
                 got.idx);
        errors++;
      end else begin
        exp_s = soln_q.pop_front();
        if (got !== exp_s) begin
          $display("%0t: expected value=%h index=%0d last=%b singular=%b", $realtime,
                   exp_s.value, exp_s.idx, exp_s.last, exp_s.sing);
          $display("%0t: actual   value=%h index=%0d last=%b singular=%b", $realtime,
                   got.value, got.idx, got.last, got.sing);
          errors++;
        end
      end
    end
  end

  initial begin
    errors      = 0;
    hold_cycles = 0;
    src_idle_en = 1;
    snk_idle_en = 1;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 5'd1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    mdl_size    = 5'd1;
    mdl_count   = 0;
    for (int i = 0; i < STORE_DEPTH; i++) mdl_store[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_backpressure();
    test_random(50);
    src_idle_en = 0;
    snk_idle_en = 0;
    test_random(20);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #80ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
